>>> design/lpf_pkg.sv
`timescale 1ns / 1ps

package lpf_pkg;

    localparam int LAMP_ROWS    = 3;
    localparam int LAMP_COLUMNS = 18;
    localparam int LAMP_TOTAL   = LAMP_ROWS * LAMP_COLUMNS;

    localparam int INPUT_ROWS = 3;
    localparam int INPUT_BITS = 18;

    localparam int ROW_W   = 2;
    localparam int COL_W   = 5;
    localparam int LEVEL_W = 5;
    localparam int COUNT_W = 8;
    localparam int GAIN_W  = 16;
    localparam int Q_W     = 16;
    localparam int INT_W   = Q_W + 1;
    localparam int PROD_W  = INT_W + GAIN_W;
    localparam int STEP_W  = $clog2(Q_W);
    localparam int BRT_W   = INT_W + 5;

    localparam logic [INT_W-1:0]  ONE_Q16   = INT_W'(1) << Q_W;
    localparam logic [BRT_W-1:0]  HALF_Q16  = BRT_W'(1) << (Q_W - 1);

    localparam int REG_ADDR_W = 4;
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_ATTACK = 2'd1;
    localparam logic [1:0] REG_DECAY  = 2'd2;

    localparam logic [COUNT_W-1:0] WINDOW_RESET = 8'd100;
    localparam logic [GAIN_W-1:0]  ATTACK_RESET = 16'd786;
    localparam logic [GAIN_W-1:0]  DECAY_RESET  = 16'd65208;

    typedef struct packed {
        logic [INPUT_BITS-1:0] lights_row0;
        logic [INPUT_BITS-1:0] lights_row1;
        logic [INPUT_BITS-1:0] lights_row2;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]   lamp_row;
        logic [COL_W-1:0]   lamp_column;
        logic [LEVEL_W-1:0] brightness;
        logic               last_of_run;
    } t_out_item;

    typedef struct packed {
        logic sample;
        logic load;
        logic div_step;
        logic mul;
        logic upd;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic window_done;
        logic saturated;
        logic last_lamp;
        logic out_free;
    } t_dp_status;

endpackage

>>> design/lamp_persistence_filter.sv
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_item (three lamp rows)
// output    out        o_valid / i_stall  o_item (row, column, brightness, last)
// config    in         apb write / read   samples, attack gain, decay factor
//
// a sample is taken only while idle; input stalls while an update run is going
// each lamp of a run steps through load, bit-serial duty division (skipped
// when its duty saturates), multiply, update, emit
// output register holds one item; run waits on i_stall at emit
// synchronous active-low reset clears counts, intensities, config, state and output valid

module lamp_persistence_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  lpf_pkg::t_in_item                 i_item,
    output logic                              o_valid,
    input  logic                              i_stall,
    output lpf_pkg::t_out_item                o_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpf_pkg::REG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [lpf_pkg::COUNT_W-1:0] r_window;
    logic [lpf_pkg::GAIN_W-1:0]  r_attack;
    logic [lpf_pkg::GAIN_W-1:0]  r_decay;
    logic                        w_wr;
    logic [1:0]                  w_index;

    lpf_pkg::t_dp_cmd            w_cmd;
    lpf_pkg::t_dp_status         w_status;

    assign pready  = 1'b1;
    assign w_wr    = psel && penable && pwrite;
    assign w_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= lpf_pkg::WINDOW_RESET;
            r_attack <= lpf_pkg::ATTACK_RESET;
            r_decay  <= lpf_pkg::DECAY_RESET;
        end else if (w_wr) begin
            unique case (w_index)
                lpf_pkg::REG_WINDOW: r_window <= pwdata[lpf_pkg::COUNT_W-1:0];
                lpf_pkg::REG_ATTACK: r_attack <= pwdata[lpf_pkg::GAIN_W-1:0];
                lpf_pkg::REG_DECAY:  r_decay  <= pwdata[lpf_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            lpf_pkg::REG_WINDOW: prdata = 32'(r_window);
            lpf_pkg::REG_ATTACK: prdata = 32'(r_attack);
            lpf_pkg::REG_DECAY:  prdata = 32'(r_decay);
            default:             prdata = '0;
        endcase
    end

    lpf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    lpf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_item   (i_item),
        .i_window (r_window),
        .i_attack (r_attack),
        .i_decay  (r_decay),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_item   (o_item)
    );

endmodule

>>> design/lpf_ctrl.sv
`timescale 1ns / 1ps

module lpf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    output lpf_pkg::t_dp_cmd    o_cmd,
    input  lpf_pkg::t_dp_status i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_MUL,
        S_UPD,
        S_EMIT
    } t_state;

    t_state                       r_state;
    logic [lpf_pkg::STEP_W-1:0]   r_step;
    logic                         w_accept;

    assign w_accept = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.sample   = w_accept;
        o_cmd.load     = (r_state == S_LOAD);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.upd      = (r_state == S_UPD);
        o_cmd.emit     = (r_state == S_EMIT) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_status.window_done) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_step <= '0;
                    if (i_status.saturated) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == lpf_pkg::STEP_W'(lpf_pkg::Q_W - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_status.out_free) begin
                        if (i_status.last_lamp) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/lpf_dp.sv
`timescale 1ns / 1ps

module lpf_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lpf_pkg::t_dp_cmd                     i_cmd,
    output lpf_pkg::t_dp_status                  o_status,
    input  lpf_pkg::t_in_item                    i_item,
    input  logic [lpf_pkg::COUNT_W-1:0]          i_window,
    input  logic [lpf_pkg::GAIN_W-1:0]           i_attack,
    input  logic [lpf_pkg::GAIN_W-1:0]           i_decay,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output lpf_pkg::t_out_item                   o_item
);

    localparam int TOTAL = lpf_pkg::LAMP_TOTAL;

    logic [lpf_pkg::INPUT_ROWS-1:0][lpf_pkg::INPUT_BITS-1:0] w_rows;
    logic [TOTAL-1:0]                 w_hit;
    logic [lpf_pkg::COUNT_W-1:0]      w_window;
    logic [lpf_pkg::COUNT_W-1:0]      w_pos_n;

    // per-lamp counters and intensities, rotated so lamp under update sits at 0
    logic [lpf_pkg::COUNT_W-1:0]      r_count [TOTAL];
    logic [lpf_pkg::INT_W-1:0]        r_ring  [TOTAL];
    logic [lpf_pkg::COUNT_W-1:0]      r_pos;

    logic [lpf_pkg::COUNT_W-1:0]      r_rem;
    logic [lpf_pkg::Q_W-1:0]          r_quot;
    logic                             r_sat;
    logic [lpf_pkg::PROD_W-1:0]       r_prod;
    logic                             r_rise;
    logic [lpf_pkg::INT_W-1:0]        r_new;
    logic [lpf_pkg::ROW_W-1:0]        r_row;
    logic [lpf_pkg::COL_W-1:0]        r_col;
    logic                             r_out_valid;
    lpf_pkg::t_out_item               r_out_item;

    logic [lpf_pkg::COUNT_W:0]        w_rem_sh;
    logic                             w_rem_ge;
    logic [lpf_pkg::INT_W-1:0]        w_duty;
    logic [lpf_pkg::INT_W-1:0]        w_cur;
    logic                             w_rise;
    logic [lpf_pkg::INT_W-1:0]        w_mul_a;
    logic [lpf_pkg::GAIN_W-1:0]       w_mul_b;
    logic [lpf_pkg::INT_W:0]          w_sum;
    logic [lpf_pkg::BRT_W-1:0]        w_scaled;
    logic                             w_last;
    logic                             w_out_free;

    assign w_rows   = {i_item.lights_row2, i_item.lights_row1, i_item.lights_row0};
    assign w_window = (i_window == '0) ? lpf_pkg::COUNT_W'(1) : i_window;
    assign w_pos_n  = r_pos + 1'b1;

    for (genvar k = 0; k < TOTAL; k++) begin : g_hit
        localparam int R = k / lpf_pkg::LAMP_COLUMNS;
        localparam int C = k % lpf_pkg::LAMP_COLUMNS;
        if (R < lpf_pkg::INPUT_ROWS && C < lpf_pkg::INPUT_BITS) begin : g_in
            assign w_hit[k] = w_rows[R][C];
        end else begin : g_off
            assign w_hit[k] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TOTAL; k++) begin
                r_count[k] <= '0;
                r_ring[k]  <= '0;
            end
            r_pos <= '0;
        end else begin
            if (i_cmd.sample) begin
                for (int k = 0; k < TOTAL; k++) begin
                    r_count[k] <= r_count[k] + lpf_pkg::COUNT_W'(w_hit[k]);
                end
                r_pos <= (w_pos_n >= w_window) ? '0 : w_pos_n;
            end else if (i_cmd.upd) begin
                for (int k = 0; k < TOTAL - 1; k++) begin
                    r_count[k] <= r_count[k+1];
                    r_ring[k]  <= r_ring[k+1];
                end
                r_count[TOTAL-1] <= '0;
                r_ring[TOTAL-1]  <= w_sum[lpf_pkg::INT_W-1:0];
            end
        end
    end

    // restoring division, one quotient bit per cycle
    assign w_rem_sh = {r_rem, 1'b0};
    assign w_rem_ge = (w_rem_sh >= {1'b0, w_window});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem  <= r_count[0];
            r_quot <= '0;
            r_sat  <= (r_count[0] >= w_window);
        end else if (i_cmd.div_step) begin
            r_rem  <= w_rem_ge ? lpf_pkg::COUNT_W'(w_rem_sh - {1'b0, w_window})
                               : w_rem_sh[lpf_pkg::COUNT_W-1:0];
            r_quot <= {r_quot[lpf_pkg::Q_W-2:0], w_rem_ge};
        end
    end

    assign w_duty  = r_sat ? lpf_pkg::ONE_Q16 : {1'b0, r_quot};
    assign w_cur   = r_ring[0];
    assign w_rise  = (w_duty >= w_cur);
    assign w_mul_a = w_rise ? (w_duty - w_cur) : w_cur;
    assign w_mul_b = w_rise ? i_attack : i_decay;
    assign w_sum   = (r_rise ? {1'b0, w_cur} : '0)
                   + {1'b0, r_prod[lpf_pkg::PROD_W-1:lpf_pkg::Q_W]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= lpf_pkg::PROD_W'(w_mul_a) * lpf_pkg::PROD_W'(w_mul_b);
            r_rise <= w_rise;
        end
        if (i_cmd.upd) begin
            r_new <= w_sum[lpf_pkg::INT_W-1:0];
        end
    end

    // intensity times 31, rounded
    assign w_scaled = (lpf_pkg::BRT_W'(r_new) << 5) - lpf_pkg::BRT_W'(r_new)
                    + lpf_pkg::HALF_Q16;

    assign w_last = (r_row == lpf_pkg::ROW_W'(lpf_pkg::LAMP_ROWS - 1))
                 && (r_col == lpf_pkg::COL_W'(lpf_pkg::LAMP_COLUMNS - 1));
    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (r_col == lpf_pkg::COL_W'(lpf_pkg::LAMP_COLUMNS - 1)) begin
                    r_col <= '0;
                    r_row <= w_last ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_item.lamp_row    <= r_row;
            r_out_item.lamp_column <= r_col;
            r_out_item.brightness  <=
                w_scaled[lpf_pkg::Q_W+lpf_pkg::LEVEL_W-1:lpf_pkg::Q_W];
            r_out_item.last_of_run <= w_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    assign o_status.window_done = (w_pos_n >= w_window);
    assign o_status.saturated   = (r_count[0] >= w_window);
    assign o_status.last_lamp   = w_last;
    assign o_status.out_free    = w_out_free;

endmodule
